// ===== design/assert_macros.svh =====
// assertion macros shared by the rtl files that carry checks
// no dependencies; take in with a bare include

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checks are off while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checks are off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/rmst_pkg.sv =====
// package for the range max segment tree: sizes, word types and the
// command and status bundles between controller and datapath. no dependencies.
package rmst_pkg;

    // tree capacity and stored value width
    localparam int MAX_LEAVES = 1024;
    localparam int VALUE_BITS = 20;

    // fixed field widths of the words
    localparam int IDX_W   = 10;
    localparam int BOUND_W = 11;
    localparam int DATA_W  = 20;
    localparam int CFG_W   = 11;

    // node space and derived widths
    localparam int NODE_COUNT = 2 * MAX_LEAVES;
    localparam int NODE_AW    = $clog2(NODE_COUNT);
    localparam int SPAN_W     = NODE_AW + 1;
    localparam int CMP_W      = (SPAN_W > BOUND_W) ? SPAN_W : BOUND_W;
    localparam int LCR_W      = $clog2(MAX_LEAVES + 1);
    localparam int LC_RESET   = (MAX_LEAVES < 1024) ? MAX_LEAVES : 1024;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // input word
    typedef struct packed {
        logic               operation;
        logic [IDX_W-1:0]   left_index;
        logic [BOUND_W-1:0] right_bound;
        logic [DATA_W-1:0]  write_value;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [DATA_W-1:0] range_max;
        logic              index_error;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic start;
        logic write_step;
        logic query_step;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic go_write;
        logic go_query;
        logic clear_last;
        logic write_last;
        logic query_done;
    } t_status;

endpackage

// ===== design/range_max_segment_tree_top.sv =====
// top level of the range max segment tree: controller plus datapath
// depends on rmst_pkg, rmst_ctrl, rmst_datapath and assert_macros.svh
//
// Range-maximum segment tree over up to 1024 leaves of 20-bit values, held in a
// 2048-word node memory with two registered read ports. Each input word either
// writes one leaf and updates its ancestors, or returns the maximum over the
// half-open leaf range [left_index, right_bound); every word gives exactly one
// result word. One word is worked on at a time. A write stores the leaf and
// then walks its ancestors up to the root, and a query walks both range
// bounds up the tree, both one level per memory read. Writes that are flagged
// and empty queries go straight to the result register. After reset the block
// sweeps zeros through the node memory with o_ready low; configuration writes
// are taken during the sweep. The leaf count register is written with
// i_cfg_we and saturates at 1024.

`include "assert_macros.svh"

module range_max_segment_tree_top
    import rmst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_word         i_word,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out_word        o_word,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_cmd    w_cmd;
    t_status w_status;

    rmst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    rmst_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_word      (i_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_word      (o_word)
    );

    // no word taken while the memory is being cleared
    `ASSERT_IMPLY(a_no_ready_in_clear, i_clk, i_rst_n, w_cmd.clear_step, !o_ready)
    // result register loads only into a free or draining slot
    `ASSERT_IMPLY(a_load_slot_free, i_clk, i_rst_n, w_cmd.out_load, (!o_valid || i_ready))
    // a loaded result is offered on the next cycle
    `ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, w_cmd.out_load, o_valid)
    // a flagged write never carries a maximum
    `ASSERT_IMPLY(a_flag_zero_max, i_clk, i_rst_n, (o_valid && o_word.index_error),
        (o_word.range_max == '0))

endmodule

// ===== design/rmst_ram.sv =====
// generic ram: one write port, two read ports, registered read data
// no dependencies
module rmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_ra_addr,
    output logic [WIDTH-1:0]         o_ra_data,
    input  logic [$clog2(DEPTH)-1:0] i_rb_addr,
    output logic [WIDTH-1:0]         o_rb_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge i_clk) begin
        o_ra_data <= r_mem[i_ra_addr];
        o_rb_data <= r_mem[i_rb_addr];
    end

endmodule

// ===== design/rmst_ctrl.sv =====
// controller for the range max segment tree: clearing, walk sequencing, handshakes
// depends on rmst_pkg
module rmst_ctrl
    import rmst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_WRITE  = 5'b00100,
        S_QUERY  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_status.go_write) begin
                        n_state = S_WRITE;
                    end else if (i_status.go_query) begin
                        n_state = S_QUERY;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_WRITE: begin
                o_cmd.write_step = 1'b1;
                if (i_status.write_last) begin
                    n_state = S_FINISH;
                end
            end
            S_QUERY: begin
                o_cmd.query_step = 1'b1;
                if (i_status.query_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // output word valid flag
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== design/rmst_datapath.sv =====
// datapath for the range max segment tree: node memory, walk registers,
// leaf count register and result register. depends on rmst_pkg and rmst_ram
module rmst_datapath
    import rmst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  t_in_word         i_word,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output t_out_word        o_word
);

    logic [NODE_AW-1:0]    r_clr_addr;
    logic [LCR_W-1:0]      r_leaf_count;
    logic [NODE_AW-1:0]    r_k;
    logic [VALUE_BITS-1:0] r_cur;
    logic [SPAN_W-1:0]     r_lo, r_hi;
    logic [VALUE_BITS-1:0] r_best;
    logic                  r_pend_a, r_pend_b;
    logic                  r_flag;
    t_out_word             r_out;

    logic [CMP_W-1:0]      w_lc, w_left, w_right, w_hi_clamp, w_leaf_sum, w_hi_sum;
    logic                  w_wr_bad, w_q_empty, w_is_write;
    logic [NODE_AW-1:0]    w_k_start, w_parent;
    logic [VALUE_BITS-1:0] w_val, w_up, w_fold_a, w_fold_b;
    logic [VALUE_BITS-1:0] w_rd_a, w_rd_b;
    logic                  w_we;
    logic [NODE_AW-1:0]    w_waddr, w_ra_addr, w_rb_addr;
    logic [VALUE_BITS-1:0] w_wdata;
    logic                  w_lo_lt_hi;

    // item setup: bounds, clamp and leaf address
    assign w_lc       = CMP_W'(r_leaf_count);
    assign w_left     = CMP_W'(i_word.left_index);
    assign w_right    = CMP_W'(i_word.right_bound);
    assign w_is_write = (i_word.operation == OP_WRITE);
    assign w_wr_bad   = (w_left >= w_lc);
    assign w_hi_clamp = (w_right > w_lc) ? w_lc : w_right;
    assign w_q_empty  = (w_left >= w_hi_clamp);
    assign w_leaf_sum = w_left + w_lc;
    assign w_hi_sum   = w_hi_clamp + w_lc;
    assign w_k_start  = NODE_AW'(w_leaf_sum);
    assign w_val      = VALUE_BITS'(i_word.write_value);

    // one tree level per cycle on the way up
    assign w_parent = r_k >> 1;
    assign w_up     = (w_rd_a > r_cur) ? w_rd_a : r_cur;

    // fold last cycle's node reads into the running max
    assign w_fold_a   = (r_pend_a && (w_rd_a > r_best)) ? w_rd_a : r_best;
    assign w_fold_b   = (r_pend_b && (w_rd_b > w_fold_a)) ? w_rd_b : w_fold_a;
    assign w_lo_lt_hi = (r_lo < r_hi);

    // status to controller
    assign o_status.go_write   = w_is_write && !w_wr_bad && (w_k_start > NODE_AW'(1));
    assign o_status.go_query   = !w_is_write && !w_q_empty;
    assign o_status.clear_last = (r_clr_addr == NODE_AW'(NODE_COUNT - 1));
    assign o_status.write_last = (w_parent == NODE_AW'(1));
    assign o_status.query_done = !w_lo_lt_hi && !r_pend_a && !r_pend_b;

    // memory port selection
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_clr_addr;
        w_wdata   = '0;
        w_ra_addr = '0;
        w_rb_addr = '0;
        if (i_cmd.clear_step) begin
            w_we = 1'b1;
        end else if (i_cmd.start) begin
            w_we      = w_is_write && !w_wr_bad;
            w_waddr   = w_k_start;
            w_wdata   = w_val;
            w_ra_addr = w_k_start ^ NODE_AW'(1);
        end else if (i_cmd.write_step) begin
            w_we      = 1'b1;
            w_waddr   = w_parent;
            w_wdata   = w_up;
            w_ra_addr = w_parent ^ NODE_AW'(1);
        end else if (i_cmd.query_step) begin
            w_ra_addr = NODE_AW'(r_lo);
            w_rb_addr = NODE_AW'({r_hi[SPAN_W-1:1], 1'b0});
        end
    end

    rmst_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_ra_addr (w_ra_addr),
        .o_ra_data (w_rd_a),
        .i_rb_addr (w_rb_addr),
        .o_rb_data (w_rd_b)
    );

    // clearing sweep address and leaf count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_leaf_count <= LCR_W'(LC_RESET);
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + NODE_AW'(1);
            end
            if (i_cfg_we) begin
                r_leaf_count <= (CMP_W'(i_cfg_wdata) > CMP_W'(MAX_LEAVES))
                    ? LCR_W'(MAX_LEAVES) : LCR_W'(i_cfg_wdata);
            end
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_flag   <= w_is_write && w_wr_bad;
            r_best   <= '0;
            r_cur    <= w_val;
            r_k      <= w_k_start;
            r_lo     <= SPAN_W'(w_leaf_sum);
            r_hi     <= SPAN_W'(w_hi_sum);
            r_pend_a <= 1'b0;
            r_pend_b <= 1'b0;
        end else if (i_cmd.write_step) begin
            r_cur <= w_up;
            r_k   <= w_parent;
        end else if (i_cmd.query_step) begin
            r_best <= w_fold_b;
            if (w_lo_lt_hi) begin
                r_pend_a <= r_lo[0];
                r_pend_b <= r_hi[0];
                r_lo     <= (r_lo + SPAN_W'(r_lo[0])) >> 1;
                r_hi     <= r_hi >> 1;
            end else begin
                r_pend_a <= 1'b0;
                r_pend_b <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.range_max   <= DATA_W'(r_best);
            r_out.index_error <= r_flag;
        end
    end

    assign o_word = r_out;

endmodule
